@@ rtl/scfpr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scfpr_pkg
// Shared types, constants and the byte-wide CRC-16-CCITT update for the
// framed packet receiver.
// ----------------------------------------------------------------------------
package scfpr_pkg;

    // frame geometry
    localparam int PAYLOAD_BYTES = 6;
    localparam int OUT_BYTES     = (PAYLOAD_BYTES < 6) ? PAYLOAD_BYTES : 6;
    localparam int PAYLOAD_W     = 48;
    localparam int CNT_W         = 3;

    // crc parameters
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // configuration register indexes and reset values
    localparam logic CFG_SYNC_FIRST  = 1'b0;
    localparam logic CFG_SYNC_SECOND = 1'b1;
    localparam logic [7:0] SYNC_FIRST_RST  = 8'hA5;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h5A;

    // frame phase codes
    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_DATA  = 3'd2,
        PH_CRCH  = 3'd3,
        PH_CRCL  = 3'd4
    } scfpr_phase_t;

    // one result from the frame parser
    typedef struct packed {
        logic                 valid;
        logic [PAYLOAD_W-1:0] payload;
        logic                 crc_good;
    } scfpr_result_t;

    // msb-first crc update over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/scfpr_frame_fsm.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scfpr_frame_fsm
// Sync hunt, payload collection and crc check, one byte per step.
// ----------------------------------------------------------------------------
module scfpr_frame_fsm
    import scfpr_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step,
    input  wire logic [7:0]    rx_byte,
    input  wire logic [7:0]    sync_first,
    input  wire logic [7:0]    sync_second,
    output scfpr_result_t      result
);

    scfpr_phase_t         phase_reg, phase_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic [15:0]          crc_reg, crc_next;
    logic [7:0]           crc_high_reg, crc_high_next;
    logic [15:0]          crc_upd;

    assign crc_upd = crc_byte(crc_reg, rx_byte);

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC1;
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
        end else if (step) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    // payload and crc high byte, no reset needed
    always_ff @(posedge aclk) begin
        if (step) begin
            payload_reg  <= payload_next;
            crc_high_reg <= crc_high_next;
        end
    end

    // next state and result
    always_comb begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        payload_next    = payload_reg;
        crc_next        = crc_reg;
        crc_high_next   = crc_high_reg;
        result.valid    = 1'b0;
        result.payload  = payload_reg;
        result.crc_good = ({crc_high_reg, rx_byte} == crc_reg);
        unique case (phase_reg)
            PH_SYNC2: begin
                if (rx_byte == sync_second) begin
                    crc_next   = crc_upd;
                    phase_next = PH_DATA;
                    count_next = '0;
                end else begin
                    phase_next = PH_SYNC1;
                    count_next = '0;
                    crc_next   = CRC_INIT;
                end
            end
            PH_DATA: begin
                // first payload byte clears the buffer
                if (count_reg == '0) begin
                    payload_next = '0;
                end
                for (int i = 0; i < OUT_BYTES; i++) begin
                    if (count_reg == CNT_W'(i)) begin
                        payload_next[8*i +: 8] = rx_byte;
                    end
                end
                crc_next = crc_upd;
                if (count_reg == CNT_W'(PAYLOAD_BYTES - 1)) begin
                    phase_next = PH_CRCH;
                    count_next = '0;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            PH_CRCH: begin
                crc_high_next = rx_byte;
                phase_next    = PH_CRCL;
            end
            PH_CRCL: begin
                result.valid = 1'b1;
                phase_next   = PH_SYNC1;
                count_next   = '0;
                crc_next     = CRC_INIT;
            end
            default: begin
                // hunting first sync, also any unused phase code
                if (rx_byte == sync_first) begin
                    crc_next   = crc_byte(CRC_INIT, rx_byte);
                    phase_next = PH_SYNC2;
                end else begin
                    phase_next = PH_SYNC1;
                    count_next = '0;
                    crc_next   = CRC_INIT;
                end
            end
        endcase
    end

`ifndef SYNTH
    // a frame always ends back in the hunt with a cleared crc
    a_frame_end_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == PH_CRCL) |=> (phase_reg == PH_SYNC1 && crc_reg == CRC_INIT))
        else $error("frame end did not restart the hunt");

    // payload index stays inside the frame
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (count_reg < CNT_W'(PAYLOAD_BYTES)))
        else $error("payload index out of range");

    // crc high byte is always followed by the crc low byte
    a_crch_to_crcl: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == PH_CRCH) |=> (phase_reg == PH_CRCL))
        else $error("crc low byte phase skipped");
`endif

endmodule
`default_nettype wire

@@ rtl/sync_framed_crc_packet_receiver_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_framed_crc_packet_receiver_core
// Framed serial packet receiver with CRC-16-CCITT check.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one received byte per transaction in s_tdata.
//   m_ channel: one transaction per complete frame, carrying the payload in
//   m_tdata and the crc match flag in m_tuser.
//   cfg port: cfg_wr_en writes cfg_wr_data into sync_first (index 0) or
//   sync_second (index 1); write only while no frame is in flight.
// Timing: a byte is registered on acceptance and processed when the parser
//   steps; the result of the crc low byte is then registered in the output
//   register and shown on m_.
// Throughput: one byte per cycle while m_ does not stall; the byte-wide crc
//   update and the phase logic sit between the input and output registers.
// Reset: synchronous, active low; the hunt restarts, the crc clears and the
//   sync values return to 0xA5 and 0x5A.
// Stall: while m_tready is low with a result pending, the parser holds the
//   registered byte and s_tready drops once the input register is full.
// ----------------------------------------------------------------------------
module sync_framed_crc_packet_receiver_core
    import scfpr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // slave side: [7:0] rx_byte
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    // master side: [47:0] frame_payload
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,
    // master side: [0] crc_good
    output logic [0:0]       m_tuser,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_index,
    input  wire logic [7:0]  cfg_wr_data
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    logic [47:0]   out_payload_reg;
    logic          out_good_reg;
    logic [7:0]    sync_first_reg;
    logic [7:0]    sync_second_reg;
    logic          step;
    scfpr_result_t result;

    // parser advances when the output side can take a possible result
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end else if (cfg_wr_en) begin
            if (cfg_wr_index == CFG_SYNC_FIRST) begin
                sync_first_reg <= cfg_wr_data;
            end else begin
                sync_second_reg <= cfg_wr_data;
            end
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    scfpr_frame_fsm u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .rx_byte     (in_byte_reg),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .result      (result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= result.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && result.valid) begin
            out_payload_reg <= result.payload;
            out_good_reg    <= result.crc_good;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_payload_reg;
    assign m_tuser[0] = out_good_reg;

`ifndef SYNTH
    // a byte waiting in the input register is never dropped
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !step) |=> in_valid_reg)
        else $error("pending byte lost");

    // a pending result is never overwritten before it is taken
    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !step)
        else $error("pending result overwritten");

    // the input register only takes a byte once the old one is consumed
    a_in_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && in_valid_reg) |-> step)
        else $error("input byte overwritten");
`endif

endmodule
`default_nettype wire
